// ----- rtl/core/mms_pkg.sv -----
`default_nettype none

package mms_pkg;

  // default store depth
  localparam int MAX_ITEMS_DEF = 32;

  // field widths
  localparam int VALUE_W  = 16;
  localparam int MEDIAN_W = 17;
  localparam int MEAN_W   = 20;
  localparam int COUNT_W  = 6;

  // Q12.4 sum to Q12.8 mean
  localparam int FRAC_SHIFT = 4;

  // one input word
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               has_value;
    logic               last;
  } item_t;

  // one result word
  typedef struct packed {
    logic [MEDIAN_W-1:0] median;
    logic [MEAN_W-1:0]   mean;
    logic [COUNT_W-1:0]  count;
    logic                empty_res;
    logic                overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/mms_ram.sv -----
`default_nettype none

module mms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/median_and_mean_of_set.sv -----
`default_nettype none

// Median and mean of a set of unsigned Q12.4 values.
// Input channel: a word (item) is taken at a rising edge with start high and
// busy low. Words without last are stored on arrival, so a new word can
// follow every cycle. A word with last closes the set; its value is stored
// first when has_value is set. Values beyond MAX_ITEMS are dropped and the
// result's overflow bit reports it.
// After last, busy stays high while the set is bubble-sorted in the store RAM
// (one compare per cycle, at most n passes), the median is read and the mean
// is computed by a restoring divider at one quotient bit per cycle.
// An empty set answers in the cycle after last with zeros and empty_res.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall it. busy falls in the same cycle.
// Reset (rst, synchronous) empties the set and returns to idle; store
// contents are not cleared since only written entries are ever read.

module median_and_mean_of_set #(
  parameter int MAX_ITEMS = mms_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mms_pkg::item_t    item,
  output logic              busy,
  output logic              done,
  output mms_pkg::result_t  result
);
  import mms_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int SUM_W = VALUE_W + CNT_W;
  localparam int DW    = SUM_W + FRAC_SHIFT;
  localparam int BIT_W = $clog2(DW);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIRST = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_END   = 8'b0000_1000,
    S_MSEL  = 8'b0001_0000,
    S_MLO   = 8'b0010_0000,
    S_MHI   = 8'b0100_0000,
    S_DIV   = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic                dropped, dropped_next;
  logic [SUM_W-1:0]    sum, sum_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [VALUE_W-1:0]  held, held_next;
  logic                swapped, swapped_next;
  logic [MEDIAN_W-1:0] med, med_next;
  logic [DW-1:0]       quo, quo_next;
  logic [CNT_W-1:0]    rem, rem_next;
  logic [BIT_W-1:0]    bitcnt, bitcnt_next;
  logic                done_next;
  result_t             result_next;

  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [VALUE_W-1:0]  wdata, rdata;

  logic                accept;
  logic                room;
  logic [IDX_W-1:0]    mid, mid_lo;
  logic [CNT_W:0]      sh;
  logic                ge;

  mms_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign room   = (cnt < CNT_W'(MAX_ITEMS));
  assign mid    = IDX_W'(cnt >> 1);
  assign mid_lo = mid - 1'b1;

  // restoring divide step: one quotient bit
  assign sh = {rem, quo[DW-1]};
  assign ge = (sh >= {1'b0, cnt});

  // sequencer and datapath next values
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dropped_next = dropped;
    sum_next     = sum;
    idx_next     = idx;
    held_next    = held;
    swapped_next = swapped;
    med_next     = med;
    quo_next     = quo;
    rem_next     = rem;
    bitcnt_next  = bitcnt;
    done_next    = 1'b0;
    result_next  = result;
    we           = 1'b0;
    waddr        = idx;
    wdata        = held;
    raddr        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // store the value if there is room
          if (item.has_value) begin
            if (room) begin
              we       = 1'b1;
              waddr    = IDX_W'(cnt);
              wdata    = item.value;
              cnt_next = cnt + 1'b1;
              sum_next = sum + SUM_W'(item.value);
            end else begin
              dropped_next = 1'b1;
            end
          end
          // close the set
          if (item.last) begin
            if (cnt_next == '0) begin
              result_next = '{median: '0, mean: '0, count: '0,
                              empty_res: 1'b1, overflow: dropped_next};
              done_next    = 1'b1;
              cnt_next     = '0;
              dropped_next = 1'b0;
              sum_next     = '0;
            end else if (cnt_next == CNT_W'(1)) begin
              state_next = S_MSEL;
            end else begin
              raddr        = '0;
              swapped_next = 1'b0;
              state_next   = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        // first entry of a pass becomes the carried value
        held_next  = rdata;
        idx_next   = '0;
        raddr      = IDX_W'(1);
        state_next = S_CMP;
      end
      S_CMP: begin
        // keep the larger value moving up, write the smaller one back
        we    = 1'b1;
        waddr = idx;
        if (held > rdata) begin
          wdata        = rdata;
          swapped_next = 1'b1;
        end else begin
          wdata     = held;
          held_next = rdata;
        end
        idx_next = idx + 1'b1;
        if ((CNT_W'(idx) + CNT_W'(2)) == cnt) begin
          state_next = S_END;
        end else begin
          raddr = IDX_W'(idx + 2'd2);
        end
      end
      S_END: begin
        // largest of the pass lands at the top
        we    = 1'b1;
        waddr = IDX_W'(cnt - 1'b1);
        wdata = held;
        if (swapped) begin
          swapped_next = 1'b0;
          raddr        = '0;
          state_next   = S_FIRST;
        end else begin
          state_next = S_MSEL;
        end
      end
      S_MSEL: begin
        raddr      = cnt[0] ? mid : mid_lo;
        state_next = S_MLO;
      end
      S_MLO: begin
        if (cnt[0]) begin
          med_next    = {rdata, 1'b0};
          quo_next    = {sum, {FRAC_SHIFT{1'b0}}};
          rem_next    = '0;
          bitcnt_next = BIT_W'(DW - 1);
          state_next  = S_DIV;
        end else begin
          med_next   = MEDIAN_W'(rdata);
          raddr      = mid;
          state_next = S_MHI;
        end
      end
      S_MHI: begin
        // sum of the two middle entries is their average in Q12.5
        med_next    = med + MEDIAN_W'(rdata);
        quo_next    = {sum, {FRAC_SHIFT{1'b0}}};
        rem_next    = '0;
        bitcnt_next = BIT_W'(DW - 1);
        state_next  = S_DIV;
      end
      S_DIV: begin
        rem_next    = ge ? CNT_W'(sh - {1'b0, cnt}) : CNT_W'(sh);
        quo_next    = {quo[DW-2:0], ge};
        bitcnt_next = bitcnt - 1'b1;
        if (bitcnt == '0) begin
          result_next = '{median: med, mean: MEAN_W'(quo_next),
                          count: COUNT_W'(cnt), empty_res: 1'b0,
                          overflow: dropped};
          done_next    = 1'b1;
          cnt_next     = '0;
          dropped_next = 1'b0;
          sum_next     = '0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      dropped <= 1'b0;
      sum     <= '0;
      swapped <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
      sum     <= sum_next;
      swapped <= swapped_next;
      done    <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    held   <= held_next;
    med    <= med_next;
    quo    <= quo_next;
    rem    <= rem_next;
    bitcnt <= bitcnt_next;
    result <= result_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mms_check.sv -----
`default_nettype none

module mms_check (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input mms_pkg::item_t   item,
  input logic             busy,
  input logic             done,
  input mms_pkg::result_t result
);
  import mms_pkg::*;

  // a result only shows once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // closing a set either starts the work or answers at once
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.last |=> busy || done)
    else $error("last word neither started work nor answered");

  // a plain word never causes a result
  a_plain_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.last |=> !busy && !done)
    else $error("plain word caused a result or busy");

  // end of work always comes with a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy fell without a result");

  // an empty set reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.empty_res |->
      result.median == '0 && result.mean == '0 && result.count == '0)
    else $error("empty set with nonzero result");

endmodule

bind median_and_mean_of_set mms_check u_mms_check (.*);

`default_nettype wire
